// ===== hdl/pcb_pkg.sv =====
// profile counter bank package: operation, status and register codes,
// stream field layout, site entry type and the log2 bucket function
// no dependencies
`default_nettype none

package pcb_pkg;

    localparam int DEFAULT_NUM_COUNTERS = 1024;
    localparam int DEFAULT_NUM_SITES    = 256;

    localparam int OP_W     = 3;
    localparam int SITE_W   = 8;
    localparam int VALUE_W  = 64;
    localparam int BUCKET_W = 32;
    localparam int CIDX_W   = 10;
    localparam int FIRST_W  = 10;
    localparam int CELLS_W  = 11;
    localparam int STATUS_W = 2;
    localparam int IDX_W    = 12;
    localparam int SIU_W    = 9;
    localparam int CIU_W    = 11;
    localparam int CFG_W    = 11;

    localparam int S_TDATA_W = 208;
    localparam int M_TDATA_W = 72;

    localparam logic [OP_W-1:0] OP_ADD        = 3'd0;
    localparam logic [OP_W-1:0] OP_BUCKET     = 3'd1;
    localparam logic [OP_W-1:0] OP_HISTOGRAM  = 3'd2;
    localparam logic [OP_W-1:0] OP_CANDIDATE  = 3'd3;
    localparam logic [OP_W-1:0] OP_READ       = 3'd4;
    localparam logic [OP_W-1:0] OP_WRITE_SITE = 3'd5;

    localparam logic [STATUS_W-1:0] STS_DONE     = 2'd0;
    localparam logic [STATUS_W-1:0] STS_IGNORED  = 2'd1;
    localparam logic [STATUS_W-1:0] STS_REJECTED = 2'd2;

    localparam logic REG_SITES_IN_USE    = 1'b0;
    localparam logic REG_COUNTERS_IN_USE = 1'b1;

    typedef struct packed {
        logic [FIRST_W-1:0] first;
        logic [CELLS_W-1:0] cells;
    } pcb_site_t;

    // 0..2 map to themselves, one bucket per power of two up to 4096,
    // bucket 14 up to 65536, bucket 15 above
    function automatic logic [3:0] log2_bucket(input logic [31:0] v);
        logic [3:0] res;
        res = 4'd15;
        if (v <= 32'd65536) begin
            res = 4'd14;
        end
        for (int k = 12; k >= 2; k--) begin
            if (v <= (32'd1 << k)) begin
                res = 4'(k + 1);
            end
        end
        if (v <= 32'd2) begin
            res = v[3:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/pcb_site_mem.sv =====
// site table memory: first counter and cell count per site
// one registered read port, one write port; uses pcb_pkg
`default_nettype none

module pcb_site_mem #(
    parameter int NUM_SITES = pcb_pkg::DEFAULT_NUM_SITES,
    localparam int ADDR_W = (NUM_SITES > 1) ? $clog2(NUM_SITES) : 1
) (
    input  wire logic              aclk,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output pcb_pkg::pcb_site_t     rd_data,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire pcb_pkg::pcb_site_t wr_data
);
    import pcb_pkg::*;

    pcb_site_t mem [NUM_SITES];
    pcb_site_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== hdl/pcb_counter_mem.sv =====
// 64-bit counter memory with a clearing sweep after reset
// one registered read port, one write port; uses pcb_pkg
`default_nettype none

module pcb_counter_mem #(
    parameter int NUM_COUNTERS = pcb_pkg::DEFAULT_NUM_COUNTERS,
    localparam int ADDR_W = $clog2(NUM_COUNTERS)
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    output logic                             busy,
    input  wire logic                        rd_en,
    input  wire logic [ADDR_W-1:0]           rd_addr,
    output logic [pcb_pkg::VALUE_W-1:0]      rd_data,
    input  wire logic                        wr_en,
    input  wire logic [ADDR_W-1:0]           wr_addr,
    input  wire logic [pcb_pkg::VALUE_W-1:0] wr_data
);
    import pcb_pkg::*;

    localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(NUM_COUNTERS - 1);

    logic [VALUE_W-1:0] mem [NUM_COUNTERS];
    logic [VALUE_W-1:0] rd_data_reg;
    logic               clearing_reg;
    logic [ADDR_W-1:0]  clr_addr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clearing_reg) begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == CLR_LAST) begin
                clearing_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (clearing_reg) begin
            mem[clr_addr_reg] <= '0;
        end else if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign busy    = clearing_reg;
    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== hdl/profile_counter_bank.sv =====
// profile counter bank top level: stream ports, item sequencer and
// saturating read-modify-write; uses pcb_pkg, pcb_site_mem, pcb_counter_mem
//
// Items arrive on the s_ stream, one transaction per item; every item gives
// exactly one result transaction on the m_ stream. sites_in_use and
// counters_in_use are set through the cfg_ write port; the user must write
// them only while the block is idle, as the block does not enforce it.
// Each item walks three steps: accept (site table read issued), site lookup
// and check (counter read issued, site table written for write-site items),
// then counter update and result load. The counter memory is read and written
// back by the same item before the next is taken, so accesses never overlap.
// A new item is taken once the last leaves the update step, as the site and
// counter memory reads run in series. The result sits in an output register,
// so the next item is accepted while it waits; if m_tready stays low the
// sequencer holds at the update step and s_tready drops until the register
// frees. After reset the counter memory is swept to zero, one entry per cycle,
// over all NUM_COUNTERS entries, with s_tready low; the overflow and
// incomplete flags and both configuration registers reset to zero.
`default_nettype none

module profile_counter_bank #(
    parameter int NUM_COUNTERS = pcb_pkg::DEFAULT_NUM_COUNTERS,
    parameter int NUM_SITES    = pcb_pkg::DEFAULT_NUM_SITES
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // operation, site, value, candidate, bucket, counter_index,
    // entry_first, entry_count
    input  wire logic [pcb_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // counter_value, counter_saturated, overflow_seen, incomplete_seen, status
    output logic [pcb_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    input  wire logic                          cfg_wr_en,
    input  wire logic                          cfg_index,
    input  wire logic [pcb_pkg::CFG_W-1:0]     cfg_wdata
);
    import pcb_pkg::*;

    localparam int CNT_AW  = $clog2(NUM_COUNTERS);
    localparam int SITE_AW = (NUM_SITES > 1) ? $clog2(NUM_SITES) : 1;
    localparam int CNT_WW  = (CNT_AW > IDX_W) ? CNT_AW : IDX_W;
    localparam int SITE_WW = (SITE_AW > SITE_W) ? SITE_AW : SITE_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SITE = 2'd1;
    localparam logic [1:0] ST_CNT  = 2'd2;

    // configuration
    logic [SIU_W-1:0] sites_in_use_reg;
    logic [CIU_W-1:0] counters_in_use_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sites_in_use_reg    <= '0;
            counters_in_use_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_SITES_IN_USE:    sites_in_use_reg    <= cfg_wdata[SIU_W-1:0];
                REG_COUNTERS_IN_USE: counters_in_use_reg <= cfg_wdata[CIU_W-1:0];
                default: ;
            endcase
        end
    end

    // input fields
    logic [OP_W-1:0]     in_op;
    logic [SITE_W-1:0]   in_site;
    logic [VALUE_W-1:0]  in_value;
    logic [VALUE_W-1:0]  in_cand;
    logic [BUCKET_W-1:0] in_bucket;
    logic [CIDX_W-1:0]   in_ci;
    logic [FIRST_W-1:0]  in_ef;
    logic [CELLS_W-1:0]  in_ec;

    assign in_op     = s_tdata[2:0];
    assign in_site   = s_tdata[10:3];
    assign in_value  = s_tdata[74:11];
    assign in_cand   = s_tdata[138:75];
    assign in_bucket = s_tdata[170:139];
    assign in_ci     = s_tdata[180:171];
    assign in_ef     = s_tdata[190:181];
    assign in_ec     = s_tdata[201:191];

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       cnt_busy;
    logic       accept;
    logic       out_free;
    logic       load_out;

    assign s_tready = (state_reg == ST_IDLE) && !cnt_busy;
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid || m_tready;
    assign load_out = (state_reg == ST_CNT) && out_free;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept) state_next = ST_SITE;
            ST_SITE: state_next = ST_CNT;
            ST_CNT:  if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // accept step: cell request for the observe kinds
    logic                wide_value;
    logic [BUCKET_W-1:0] hist_value;
    logic [BUCKET_W-1:0] cell_req;

    assign wide_value = |in_value[VALUE_W-1:BUCKET_W];
    assign hist_value = wide_value ? '1 : in_value[BUCKET_W-1:0];

    always_comb begin
        case (in_op)
            OP_HISTOGRAM: cell_req = BUCKET_W'(log2_bucket(hist_value));
            OP_CANDIDATE: cell_req = (in_value == in_cand) ? '0 : BUCKET_W'(1);
            default:      cell_req = in_bucket;
        endcase
    end

    logic [OP_W-1:0]     op_reg;
    logic [SITE_W-1:0]   site_reg;
    logic [VALUE_W-1:0]  value_reg;
    logic [BUCKET_W-1:0] cell_req_reg;
    logic [CIDX_W-1:0]   ci_reg;
    logic [FIRST_W-1:0]  ef_reg;
    logic [CELLS_W-1:0]  ec_reg;

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg       <= in_op;
            site_reg     <= in_site;
            value_reg    <= in_value;
            cell_req_reg <= cell_req;
            ci_reg       <= in_ci;
            ef_reg       <= in_ef;
            ec_reg       <= in_ec;
        end
    end

    logic incomplete_reg;
    logic overflow_reg;

    // site table
    logic [SITE_WW-1:0] in_site_wide;
    logic [SITE_WW-1:0] site_reg_wide;
    pcb_site_t          site_rd;
    pcb_site_t          site_wr;
    logic               site_wr_en;

    assign in_site_wide  = SITE_WW'(in_site);
    assign site_reg_wide = SITE_WW'(site_reg);
    assign site_wr.first = ef_reg;
    assign site_wr.cells = ec_reg;

    pcb_site_mem #(
        .NUM_SITES (NUM_SITES)
    ) u_site_mem (
        .aclk    (aclk),
        .rd_en   (accept),
        .rd_addr (in_site_wide[SITE_AW-1:0]),
        .rd_data (site_rd),
        .wr_en   (site_wr_en),
        .wr_addr (site_reg_wide[SITE_AW-1:0]),
        .wr_data (site_wr)
    );

    // site step: clamp, index, liveness and site entry check
    logic [31:0]        cnt_lim;
    logic               site_live;
    logic [CELLS_W-1:0] slot;
    logic [IDX_W-1:0]   obs_idx;
    logic [IDX_W-1:0]   idx;
    logic               idx_live;
    logic               site_reject;
    logic [STATUS_W-1:0] sts;
    logic               bump;
    logic               rd_sel;
    logic [CNT_WW-1:0]  idx_wide;
    logic [CNT_AW-1:0]  cnt_addr;

    assign cnt_lim = (32'(counters_in_use_reg) < 32'(NUM_COUNTERS)) ?
                     32'(counters_in_use_reg) : 32'(NUM_COUNTERS);
    assign site_live = (SIU_W'(site_reg) < sites_in_use_reg) &&
                       (32'(site_reg) < 32'(NUM_SITES));

    always_comb begin
        if (site_rd.cells == '0) begin
            slot = '0;
        end else if (cell_req_reg >= BUCKET_W'(site_rd.cells)) begin
            slot = site_rd.cells - 1'b1;
        end else begin
            slot = cell_req_reg[CELLS_W-1:0];
        end
    end

    assign obs_idx = IDX_W'(site_rd.first) + IDX_W'(slot);

    always_comb begin
        case (op_reg)
            OP_ADD:  idx = IDX_W'(site_rd.first);
            OP_READ: idx = IDX_W'(ci_reg);
            default: idx = obs_idx;
        endcase
    end

    assign idx_live    = 32'(idx) < cnt_lim;
    assign site_reject = (32'(site_reg) >= 32'(NUM_SITES)) || (ec_reg == '0) ||
                         ((32'(ef_reg) + 32'(ec_reg)) > cnt_lim);
    assign site_wr_en  = (state_reg == ST_SITE) && (op_reg == OP_WRITE_SITE) &&
                         !site_reject;
    assign idx_wide    = CNT_WW'(idx);
    assign cnt_addr    = idx_wide[CNT_AW-1:0];

    always_comb begin
        sts    = STS_IGNORED;
        bump   = 1'b0;
        rd_sel = 1'b0;
        unique case (op_reg) inside
            OP_ADD, OP_BUCKET, OP_HISTOGRAM, OP_CANDIDATE: begin
                if (site_live && idx_live) begin
                    sts  = STS_DONE;
                    bump = 1'b1;
                end
            end
            OP_READ: begin
                if (idx_live) begin
                    sts    = STS_DONE;
                    rd_sel = 1'b1;
                end
            end
            OP_WRITE_SITE: begin
                sts = site_reject ? STS_REJECTED : STS_DONE;
            end
            default: ;
        endcase
    end

    logic [STATUS_W-1:0] sts_reg;
    logic                bump_reg;
    logic                rd_sel_reg;
    logic [VALUE_W-1:0]  amt_reg;
    logic [CNT_AW-1:0]   cnt_addr_reg;

    always_ff @(posedge aclk) begin
        if (state_reg == ST_SITE) begin
            sts_reg      <= sts;
            bump_reg     <= bump;
            rd_sel_reg   <= rd_sel;
            amt_reg      <= (op_reg == OP_ADD) ? value_reg : VALUE_W'(1);
            cnt_addr_reg <= cnt_addr;
        end
    end

    // counter step: saturating add and result
    logic [VALUE_W-1:0] cnt_q;
    logic [VALUE_W-1:0] cnt_new;
    logic               cnt_wr_en;
    logic               sat_hit;

    pcb_counter_mem #(
        .NUM_COUNTERS (NUM_COUNTERS)
    ) u_counter_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .busy    (cnt_busy),
        .rd_en   (state_reg == ST_SITE),
        .rd_addr (cnt_addr),
        .rd_data (cnt_q),
        .wr_en   (cnt_wr_en),
        .wr_addr (cnt_addr_reg),
        .wr_data (cnt_new)
    );

    assign sat_hit   = amt_reg > ~cnt_q;
    assign cnt_new   = sat_hit ? '1 : cnt_q + amt_reg;
    assign cnt_wr_en = load_out && bump_reg && (amt_reg != '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            overflow_reg   <= 1'b0;
            incomplete_reg <= 1'b0;
        end else begin
            if (cnt_wr_en && sat_hit) begin
                overflow_reg <= 1'b1;
            end
            if (accept && (in_op == OP_HISTOGRAM) && wide_value) begin
                incomplete_reg <= 1'b1;
            end
        end
    end

    logic [VALUE_W-1:0]   res_value;
    logic                 res_sat;
    logic                 res_ovf;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic                 m_tvalid_reg;

    assign res_value = rd_sel_reg ? cnt_q : '0;
    assign res_sat   = rd_sel_reg && (&cnt_q);
    assign res_ovf   = overflow_reg || (cnt_wr_en && sat_hit);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_tdata_reg <= {3'b000, sts_reg, incomplete_reg, res_ovf, res_sat, res_value};
        end
    end

    assign m_tdata  = m_tdata_reg;
    assign m_tvalid = m_tvalid_reg;

`ifndef ASSERT_OFF
    a_no_accept_in_sweep : assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_busy |-> !s_tready)
        else $error("item accepted during counter sweep");

    a_accept_to_site : assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == ST_SITE))
        else $error("accepted item did not reach site step");

    a_write_in_cnt : assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_wr_en |-> (state_reg == ST_CNT) && bump_reg && out_free)
        else $error("counter written outside the update step");

    a_result_loaded : assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |=> m_tvalid && (state_reg == ST_IDLE))
        else $error("result not presented after update step");

    a_sat_only_read : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[64]) |-> (m_tdata[68:67] == STS_DONE))
        else $error("saturated flag on a result that is not a completed read");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_profile_counter_bank.sv =====
// testbench for profile_counter_bank: directed and random items on the s_ stream,
// results on the m_ stream checked against a mirror of counters, site table and flags
// depends on pcb_pkg and profile_counter_bank
module tb_profile_counter_bank;
    import pcb_pkg::*;

    localparam int N_COUNTERS     = DEFAULT_NUM_COUNTERS;
    localparam int N_SITES        = DEFAULT_NUM_SITES;
    localparam int WATCHDOG_LIMIT = 4096;
    localparam int PHASE_ITEMS    = 100;

    localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [CELLS_W-1:0]  entry_count;
        logic [FIRST_W-1:0]  entry_first;
        logic [CIDX_W-1:0]   counter_index;
        logic [BUCKET_W-1:0] bucket;
        logic [VALUE_W-1:0]  candidate;
        logic [VALUE_W-1:0]  value;
        logic [SITE_W-1:0]   site;
        logic [OP_W-1:0]     op;
    } event_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                incomplete_seen;
        logic                overflow_seen;
        logic                counter_saturated;
        logic [VALUE_W-1:0]  counter_value;
    } reading_t;

    localparam int EVENT_W  = $bits(event_t);
    localparam int READING_W = $bits(reading_t);

    class bank_mirror;
        logic [VALUE_W-1:0] counters [N_COUNTERS];
        logic [FIRST_W-1:0] first_of_site [N_SITES];
        logic [CELLS_W-1:0] site_cells [N_SITES];
        bit                 site_written [N_SITES];
        bit                 overflow;
        bit                 incomplete;
        int unsigned        sites_live;
        int unsigned        counters_live;
        reading_t           due_results [$];
        int unsigned        failures;

        function new();
            foreach (counters[i]) counters[i] = '0;
            foreach (site_written[i]) begin
                site_written[i] = 1'b0;
                first_of_site[i] = '0;
                site_cells[i] = '0;
            end
            overflow = 1'b0;
            incomplete = 1'b0;
            sites_live = 0;
            counters_live = 0;
            failures = 0;
        endfunction

        function void set_register(logic idx, logic [CFG_W-1:0] v);
            if (idx == REG_SITES_IN_USE) begin
                sites_live = v[SIU_W-1:0];
            end else begin
                counters_live = v[CIU_W-1:0];
            end
        endfunction

        function int unsigned counter_limit();
            return counters_live < N_COUNTERS ? counters_live : N_COUNTERS;
        endfunction

        function bit site_active(int unsigned s);
            return s < sites_live && s < N_SITES;
        endfunction

        function logic [STATUS_W-1:0] add_to(int unsigned idx, logic [VALUE_W-1:0] amount);
            if (idx >= counter_limit()) return STS_IGNORED;
            if (amount != 0) begin
                if (amount > ~counters[idx]) begin
                    counters[idx] = '1;
                    overflow = 1'b1;
                end else begin
                    counters[idx] = counters[idx] + amount;
                end
            end
            return STS_DONE;
        endfunction

        function logic [STATUS_W-1:0] count_cell(int unsigned s, logic [BUCKET_W-1:0] b);
            int unsigned slot;
            if (!site_active(s)) return STS_IGNORED;
            if (site_cells[s] == 0) begin
                slot = 0;
            end else if (b >= site_cells[s]) begin
                slot = site_cells[s] - 1;
            end else begin
                slot = b;
            end
            return add_to(first_of_site[s] + slot, 64'd1);
        endfunction

        // 0..2 as is, then ceil(log2 v) + 1 up to 4096, 14 up to 65536, 15 above
        function int unsigned hist_bin(logic [31:0] v);
            int unsigned width;
            logic [31:0] rest;
            if (v <= 2) return v;
            if (v > 65536) return 15;
            if (v > 4096) return 14;
            width = 0;
            rest = v - 1;
            while (rest != 0) begin
                width++;
                rest = rest >> 1;
            end
            return width + 1;
        endfunction

        function void apply_item(event_t e);
            reading_t r;
            logic [VALUE_W-1:0] v;
            int unsigned lim;
            r = '0;
            r.status = STS_IGNORED;
            case (e.op)
                OP_ADD: begin
                    if (site_active(e.site)) r.status = add_to(first_of_site[e.site], e.value);
                end
                OP_BUCKET: begin
                    r.status = count_cell(e.site, e.bucket);
                end
                OP_HISTOGRAM: begin
                    v = e.value;
                    if (v > 64'hFFFF_FFFF) begin
                        incomplete = 1'b1;
                        v = 64'hFFFF_FFFF;
                    end
                    r.status = count_cell(e.site, hist_bin(v[31:0]));
                end
                OP_CANDIDATE: begin
                    r.status = count_cell(e.site, (e.value == e.candidate) ? 0 : 1);
                end
                OP_READ: begin
                    if (e.counter_index < counter_limit()) begin
                        r.counter_value = counters[e.counter_index];
                        r.counter_saturated = &counters[e.counter_index];
                        r.status = STS_DONE;
                    end
                end
                OP_WRITE_SITE: begin
                    lim = counter_limit();
                    if (e.site >= N_SITES || e.entry_count == 0 || e.entry_first > lim
                            || e.entry_count > lim - e.entry_first) begin
                        r.status = STS_REJECTED;
                    end else begin
                        first_of_site[e.site] = e.entry_first;
                        site_cells[e.site] = e.entry_count;
                        site_written[e.site] = 1'b1;
                        r.status = STS_DONE;
                    end
                end
                default: begin
                end
            endcase
            r.overflow_seen = overflow;
            r.incomplete_seen = incomplete;
            due_results.push_back(r);
        endfunction

        function void flag_field(string field, logic [63:0] want, logic [63:0] got);
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
            failures++;
        endfunction

        function void compare_result(reading_t got);
            reading_t want;
            if (due_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                failures++;
                return;
            end
            want = due_results.pop_front();
            if (got.counter_value !== want.counter_value)
                flag_field("counter_value", want.counter_value, got.counter_value);
            if (got.counter_saturated !== want.counter_saturated)
                flag_field("counter_saturated", want.counter_saturated, got.counter_saturated);
            if (got.overflow_seen !== want.overflow_seen)
                flag_field("overflow_seen", want.overflow_seen, got.overflow_seen);
            if (got.incomplete_seen !== want.incomplete_seen)
                flag_field("incomplete_seen", want.incomplete_seen, got.incomplete_seen);
            if (got.status !== want.status)
                flag_field("status", want.status, got.status);
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    event_t                s_item = '0;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tvalid;
    logic                  m_tready = 1'b1;
    logic                  cfg_wr_en = 1'b0;
    logic                  cfg_index = REG_SITES_IN_USE;
    logic [CFG_W-1:0]      cfg_wdata = '0;

    bank_mirror mirror = new();
    bit         quiet_tail = 1'b0;
    int         quiet_cycles = 0;
    int         ready_hold = 0;

    assign s_tdata = {{(S_TDATA_W - EVENT_W){1'b0}}, s_item};

    profile_counter_bank DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // transaction monitor and progress count
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) mirror.apply_item(s_item);
            if (m_tvalid && m_tready) mirror.compare_result(reading_t'(m_tdata[READING_W-1:0]));
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // receiver back-pressure bursts
    always @(negedge aclk) begin
        if (quiet_tail) begin
            m_tready <= 1'b1;
            ready_hold <= 0;
        end else if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
        end else if ($urandom_range(0, 5) != 0) begin
            m_tready <= 1'b1;
            ready_hold <= $urandom_range(0, 30);
        end else begin
            m_tready <= 1'b0;
            ready_hold <= $urandom_range(0, 16);
        end
    end

    function automatic logic [63:0] wide_random();
        return {$urandom, $urandom};
    endfunction

    function automatic event_t ev(logic [OP_W-1:0] op, logic [SITE_W-1:0] site,
                                  logic [VALUE_W-1:0] value, logic [VALUE_W-1:0] candidate,
                                  logic [BUCKET_W-1:0] bucket, logic [CIDX_W-1:0] cidx,
                                  logic [FIRST_W-1:0] first, logic [CELLS_W-1:0] count);
        event_t e;
        e.op = op;
        e.site = site;
        e.value = value;
        e.candidate = candidate;
        e.bucket = bucket;
        e.counter_index = cidx;
        e.entry_first = first;
        e.entry_count = count;
        return e;
    endfunction

    // a written site, or a dead one; -1 when neither exists
    function automatic int choose_site();
        int s;
        int unsigned live;
        live = mirror.sites_live < N_SITES ? mirror.sites_live : N_SITES;
        if (live < N_SITES && $urandom_range(0, 9) == 0) return $urandom_range(live, N_SITES - 1);
        repeat (8) begin
            s = (live > 0) ? $urandom_range(0, live - 1) : $urandom_range(0, N_SITES - 1);
            if (mirror.site_written[s]) return s;
        end
        for (int i = 0; i < N_SITES; i++) begin
            if (mirror.site_written[i]) return i;
        end
        if (live < N_SITES) return $urandom_range(live, N_SITES - 1);
        return -1;
    endfunction

    function automatic event_t random_event();
        event_t e;
        int unsigned pick;
        int unsigned lim;
        int unsigned live;
        int unsigned span;
        int s;
        e.op = OP_SPARE_6;
        e.site = SITE_W'($urandom);
        e.value = wide_random();
        e.candidate = wide_random();
        e.bucket = $urandom;
        e.counter_index = CIDX_W'($urandom);
        e.entry_first = FIRST_W'($urandom);
        e.entry_count = CELLS_W'($urandom);
        lim = mirror.counter_limit();
        live = mirror.sites_live < N_SITES ? mirror.sites_live : N_SITES;
        pick = $urandom_range(0, 99);
        s = 0;
        if (pick >= 29) begin
            s = choose_site();
            if (s < 0) pick = 0;
        end
        if (pick < 12) begin
            e.op = OP_WRITE_SITE;
            if (live > 0 && $urandom_range(0, 3) != 0) e.site = SITE_W'($urandom_range(0, live - 1));
            if (lim > 0 && $urandom_range(0, 9) != 0) begin
                e.entry_first = FIRST_W'($urandom_range(0, lim - 1));
                span = lim - e.entry_first;
                if ($urandom_range(0, 3) == 0) begin
                    e.entry_count = CELLS_W'($urandom_range(1, span));
                end else begin
                    e.entry_count = CELLS_W'($urandom_range(1, span < 20 ? span : 20));
                end
            end
        end else if (pick < 27) begin
            e.op = OP_READ;
            if (lim > 0 && $urandom_range(0, 3) != 0)
                e.counter_index = CIDX_W'($urandom_range(0, lim - 1));
        end else if (pick < 29) begin
            e.op = (pick == 27) ? OP_SPARE_6 : OP_SPARE_7;
        end else begin
            e.site = SITE_W'(s);
            case ($urandom_range(0, 3))
                0: e.op = OP_ADD;
                1: e.op = OP_BUCKET;
                2: e.op = OP_HISTOGRAM;
                default: e.op = OP_CANDIDATE;
            endcase
            case (e.op)
                OP_ADD: begin
                    case ($urandom_range(0, 9))
                        0: e.value = '0;
                        6: e.value = wide_random() >> $urandom_range(0, 63);
                        7: e.value = wide_random();
                        8: e.value = '1 - $urandom_range(0, 3);
                        default: e.value = VALUE_W'($urandom_range(1, 1000));
                    endcase
                end
                OP_BUCKET: begin
                    if ($urandom_range(0, 1) != 0) e.bucket = $urandom_range(0, 40);
                end
                OP_HISTOGRAM: begin
                    if ($urandom_range(0, 7) != 0) e.value = e.value >> $urandom_range(0, 63);
                end
                default: begin
                    if ($urandom_range(0, 1) != 0) e.candidate = e.value;
                end
            endcase
        end
        return e;
    endfunction

    task automatic offer_event(input bit draw, input event_t fixed);
        int unsigned gap;
        gap = (!quiet_tail && $urandom_range(0, 7) == 0) ? $urandom_range(1, 17) : 0;
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_item <= draw ? random_event() : fixed;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (mirror.due_results.size() != 0) @(posedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_register(input logic idx, input int unsigned v);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v[CFG_W-1:0];
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        mirror.set_register(idx, v[CFG_W-1:0]);
    endtask

    task automatic configure(input int unsigned sites, input int unsigned counters);
        settle();
        write_register(REG_SITES_IN_USE, sites);
        write_register(REG_COUNTERS_IN_USE, counters);
    endtask

    initial begin
        while (quiet_cycles < WATCHDOG_LIMIT) @(posedge aclk);
        $display("profile_counter_bank test failed");
        $finish;
    end

    initial begin
        int unsigned sites;
        int unsigned counters;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        do @(posedge aclk); while (!s_tready);

        // site table set-up; only sites 0 and 1 live
        configure(2, N_COUNTERS);
        offer_event(0, ev(OP_WRITE_SITE, 0, 0, 0, 0, 0, 0, 16));
        offer_event(0, ev(OP_WRITE_SITE, 1, 0, 0, 0, 0, 16, 2));
        offer_event(0, ev(OP_WRITE_SITE, 2, 0, 0, 0, 0, 1023, 1));
        offer_event(0, ev(OP_WRITE_SITE, 3, 0, 0, 0, 0, 5, 0));
        offer_event(0, ev(OP_WRITE_SITE, 4, 0, 0, 0, 0, 1000, 25));
        offer_event(0, ev(OP_WRITE_SITE, 255, 0, 0, 0, 0, 18, 1006));
        offer_event(0, ev(OP_WRITE_SITE, 5, 0, 0, 0, 0, 0, 1024));
        offer_event(0, ev(OP_HISTOGRAM, 2, 64'h1_0000_0000, 0, 0, 0, 0, 0));
        offer_event(0, ev(OP_ADD, 255, 5, 0, 0, 0, 0, 0));

        // saturation, clamping and histogram edges
        configure(N_SITES, N_COUNTERS);
        offer_event(0, ev(OP_ADD, 2, '1, 0, 0, 0, 0, 0));
        offer_event(0, ev(OP_ADD, 2, 1, 0, 0, 0, 0, 0));
        offer_event(0, ev(OP_READ, 0, 0, 0, 0, 1023, 0, 0));
        offer_event(0, ev(OP_ADD, 0, 0, 0, 0, 0, 0, 0));
        offer_event(0, ev(OP_BUCKET, 0, 0, 0, '1, 0, 0, 0));
        offer_event(0, ev(OP_BUCKET, 5, 0, 0, 1023, 0, 0, 0));
        offer_event(0, ev(OP_HISTOGRAM, 0, 0, 0, 0, 0, 0, 0));
        offer_event(0, ev(OP_HISTOGRAM, 0, 4097, 0, 0, 0, 0, 0));
        offer_event(0, ev(OP_HISTOGRAM, 0, 65537, 0, 0, 0, 0, 0));
        offer_event(0, ev(OP_HISTOGRAM, 0, '1, 0, 0, 0, 0, 0));
        offer_event(0, ev(OP_CANDIDATE, 1, 64'hA5A5_0000_FFFF_1234, 64'hA5A5_0000_FFFF_1234,
                          0, 0, 0, 0));
        offer_event(0, ev(OP_CANDIDATE, 1, 64'hA5A5_0000_FFFF_1234, 64'hA5A5_0000_FFFF_1235,
                          0, 0, 0, 0));
        offer_event(0, ev(OP_SPARE_6, '1, '1, '1, '1, '1, '1, '1));

        // dead counters and a rejected entry with a small bank
        configure(3, 17);
        offer_event(0, ev(OP_BUCKET, 2, 0, 0, 0, 0, 0, 0));
        offer_event(0, ev(OP_READ, 0, 0, 0, 0, 1023, 0, 0));
        offer_event(0, ev(OP_WRITE_SITE, 6, 0, 0, 0, 0, 0, 18));

        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                1: begin
                    sites = $urandom_range(1, N_SITES);
                    counters = $urandom_range(1, N_COUNTERS);
                end
                2: begin
                    sites = 0;
                    counters = 0;
                end
                4: begin
                    sites = 1;
                    counters = 2;
                end
                5: begin
                    sites = $urandom_range(1, N_SITES);
                    counters = N_COUNTERS;
                end
                6: begin
                    sites = N_SITES;
                    counters = $urandom_range(0, N_COUNTERS);
                end
                default: begin
                    sites = N_SITES;
                    counters = N_COUNTERS;
                end
            endcase
            configure(sites, counters);
            if (phase == 7) quiet_tail = 1'b1;
            repeat (PHASE_ITEMS) offer_event(1, '0);
        end

        settle();
        repeat (4) @(posedge aclk);
        if (mirror.failures == 0 && mirror.due_results.size() == 0) begin
            $display("profile_counter_bank test passed");
        end else begin
            $display("profile_counter_bank test failed");
        end
        $finish;
    end

endmodule
